FILE: rtl/mqsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared sizes, codes and transaction types of the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int NUM_SLOTS  = 16;
    localparam int SIX_W      = $clog2(NUM_SLOTS);
    localparam int QIX_W      = $clog2(NUM_QUEUES);
    localparam int DATA_W     = 32;
    localparam int QID_W      = 2;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = 32'sh7FFF_FFFF;

    typedef logic [SIX_W-1:0] t_six;
    typedef logic [QIX_W-1:0] t_qix;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_func                    func;
        logic [QID_W-1:0]         queue_id;
        logic signed [DATA_W-1:0] item;
    } t_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        t_status                  status;
        logic                     store_full;
        logic                     queue_empty;
    } t_res;

endpackage
`default_nettype wire

FILE: rtl/mqsb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_if
// Valid/ready channels for operation requests and operation results.
// ----------------------------------------------------------------------------
interface mqsb_in_if;
    import mqsb_pkg::*;

    logic                     valid;
    logic                     ready;
    t_func                    func;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] item;

    modport source (output valid, output func, output queue_id, output item, input ready);
    modport sink   (input valid, input func, input queue_id, input item, output ready);
endinterface

interface mqsb_out_if;
    import mqsb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    t_status                  status;
    logic                     store_full;
    logic                     queue_empty;

    modport source (output valid, output data_out, output status, output store_full,
                    output queue_empty, input ready);
    modport sink   (input valid, input data_out, input status, input store_full,
                    input queue_empty, output ready);
endinterface
`default_nettype wire

FILE: rtl/mqsb_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_engine
// Slot store, link table, queue pointers, free list; one op a cycle when i_do.
// ----------------------------------------------------------------------------
module mqsb_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_do,
    input  wire mqsb_pkg::t_op i_op,
    output mqsb_pkg::t_res     o_res
);
    import mqsb_pkg::*;

    logic signed [DATA_W-1:0] r_data [NUM_SLOTS];
    t_six                     r_link [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     r_link_ok;
    t_six                     r_head [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]    r_head_ok;
    t_six                     r_tail [NUM_QUEUES];
    t_six                     r_free_head;
    logic                     r_free_ok;

    t_six                     n_link [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     n_link_ok;
    t_six                     n_head [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]    n_head_ok;
    t_six                     n_tail [NUM_QUEUES];
    t_six                     n_free_head;
    logic                     n_free_ok;

    t_qix                     w_q;
    t_six                     w_hs;
    t_six                     w_tl;
    logic                     w_data_we;

    assign w_q  = t_qix'(i_op.queue_id);
    assign w_hs = r_head[w_q];
    assign w_tl = r_tail[w_q];

    always_comb begin
        n_link      = r_link;
        n_link_ok   = r_link_ok;
        n_head      = r_head;
        n_head_ok   = r_head_ok;
        n_tail      = r_tail;
        n_free_head = r_free_head;
        n_free_ok   = r_free_ok;
        w_data_we   = 1'b0;
        o_res.data_out = '0;
        o_res.status   = ST_OK;

        case (i_op.func)
            FUNC_ENQ: begin
                if (!r_free_ok) begin
                    o_res.status = ST_OVERFLOW;
                end else begin
                    w_data_we   = 1'b1;
                    n_free_head = r_link[r_free_head];
                    n_free_ok   = r_link_ok[r_free_head];
                    if (!r_head_ok[w_q]) begin
                        n_head[w_q]    = r_free_head;
                        n_head_ok[w_q] = 1'b1;
                    end else begin
                        n_link[w_tl]    = r_free_head;
                        n_link_ok[w_tl] = 1'b1;
                    end
                    // new tail slot ends the chain
                    n_link_ok[r_free_head] = 1'b0;
                    n_tail[w_q]            = r_free_head;
                end
            end
            FUNC_DEQ: begin
                if (!r_head_ok[w_q]) begin
                    o_res.status   = ST_UNDERFLOW;
                    o_res.data_out = EMPTY_VALUE;
                end else begin
                    o_res.data_out = r_data[w_hs];
                    n_head[w_q]    = r_link[w_hs];
                    n_head_ok[w_q] = r_link_ok[w_hs];
                    // released slot goes to the front of the free list
                    n_link[w_hs]    = r_free_head;
                    n_link_ok[w_hs] = r_free_ok;
                    n_free_head     = w_hs;
                    n_free_ok       = 1'b1;
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase

        o_res.store_full  = !n_free_ok;
        o_res.queue_empty = !n_head_ok[w_q];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_link[i]    <= t_six'((i + 1) % NUM_SLOTS);
                r_link_ok[i] <= (i + 1) < NUM_SLOTS;
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            r_head_ok   <= '0;
            r_free_head <= '0;
            r_free_ok   <= 1'b1;
        end else if (i_do) begin
            r_link      <= n_link;
            r_link_ok   <= n_link_ok;
            r_head      <= n_head;
            r_head_ok   <= n_head_ok;
            r_tail      <= n_tail;
            r_free_head <= n_free_head;
            r_free_ok   <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_do && w_data_we) begin
            r_data[r_free_head] <= i_op.item;
        end
    end

    a_ovf_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_do && o_res.status == ST_OVERFLOW |=> $stable(r_head_ok) && !r_free_ok)
        else $error("overflow changed queue state");

    a_udf_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_do && o_res.status == ST_UNDERFLOW |=> $stable(r_free_head) && $stable(r_free_ok))
        else $error("underflow changed free list");

    a_deq_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_do && i_op.func == FUNC_DEQ && o_res.status == ST_OK
        |=> r_free_ok && r_free_head == $past(w_hs))
        else $error("dequeued slot not at front of free list");

    a_enq_links_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_do && i_op.func == FUNC_ENQ && o_res.status == ST_OK
        |=> r_head_ok[$past(w_q)] && r_tail[$past(w_q)] == $past(r_free_head))
        else $error("enqueued slot not at queue tail");

endmodule
`default_nettype wire

FILE: rtl/multi_queue_shared_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Four FIFO queues kept as linked lists in one shared store of sixteen slots.
// ----------------------------------------------------------------------------
// One enqueue or dequeue transaction is accepted every cycle while results are
// taken. A request is captured in an input register, resolved in a single pass
// through the pointer and link register file once the output register can take
// its result, and the result is then registered there; sustained throughput is
// one operation per cycle while results are taken.
// Every request returns exactly one result: overflow on enqueue when no slot
// is free, underflow (data 2147483647) on dequeue of an empty queue, both
// leaving the state untouched. No clearing pass follows reset.
module multi_queue_shared_buffer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mqsb_in_if.sink    i_in,
    mqsb_out_if.source o_out
);
    import mqsb_pkg::*;

    logic r_in_v;
    t_op  r_in;
    logic r_out_v;
    t_res r_out;
    t_res w_res;
    logic w_move;

    assign w_move      = r_in_v && (!r_out_v || o_out.ready);
    assign i_in.ready  = !r_in_v || w_move;

    mqsb_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_do    (w_move),
        .i_op    (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_v <= 1'b1;
            end else if (w_move) begin
                r_in_v <= 1'b0;
            end
            if (w_move) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.func     <= i_in.func;
            r_in.queue_id <= i_in.queue_id;
            r_in.item     <= i_in.item;
        end
        if (w_move) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.data_out    = r_out.data_out;
    assign o_out.status      = r_out.status;
    assign o_out.store_full  = r_out.store_full;
    assign o_out.queue_empty = r_out.queue_empty;

endmodule
`default_nettype wire
